@@ hdl/tbsfd_pkg.sv @@
// Shared constants, types and helpers for the three-bit symbol frame decoder.
package tbsfd_pkg;

    localparam int DECODED_BYTES = 9;
    localparam int TOTAL_BITS    = DECODED_BYTES * 8;
    localparam int NEED_BYTES    = ((TOTAL_BITS - 1) * 3 + 1) / 8 + 1;
    localparam int CNT_W         = $clog2(NEED_BYTES + 1);

    localparam logic [CNT_W-1:0] NEED_CNT = CNT_W'(NEED_BYTES);

    localparam logic [7:0] MARK_A = 8'hAA;
    localparam logic [7:0] MARK_B = 8'hDD;
    localparam logic [7:0] MARK_C = 8'h46;

    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_SHORT    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SLOT_A = 2'd0,
        SLOT_B = 2'd1,
        SLOT_C = 2'd2
    } t_slot;

    typedef struct packed {
        logic                  done;
        logic                  short_frame;
        logic [TOTAL_BITS-1:0] bits;
    } t_frame;

    typedef struct packed {
        t_status     status;
        logic [15:0] unit_id;
        logic [7:0]  command_code;
    } t_result;

    function automatic logic [7:0] get_byte(input logic [TOTAL_BITS-1:0] bits, input int idx);
        get_byte = bits[TOTAL_BITS - 1 - 8 * idx -: 8];
    endfunction

endpackage

@@ hdl/tbsfd_symbol_decoder.sv @@
// Symbol middle-bit extraction into the decoded bit register, with byte count.
module tbsfd_symbol_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_last_byte,
    output tbsfd_pkg::t_frame   o_frame
);

    logic [tbsfd_pkg::CNT_W-1:0]      r_count, n_count;
    tbsfd_pkg::t_slot                 r_slot, n_slot;
    logic [tbsfd_pkg::TOTAL_BITS-1:0] r_bits, n_bits;
    logic                             take;

    assign take = i_accept && (r_count < tbsfd_pkg::NEED_CNT);

    always_comb begin
        n_count = r_count;
        n_slot  = r_slot;
        n_bits  = r_bits;
        if (take) begin
            n_count = r_count + 1'b1;
            case (r_slot)
                tbsfd_pkg::SLOT_A: begin
                    n_bits = {r_bits[tbsfd_pkg::TOTAL_BITS-4:0],
                              i_rx_byte[6], i_rx_byte[3], i_rx_byte[0]};
                    n_slot = tbsfd_pkg::SLOT_B;
                end
                tbsfd_pkg::SLOT_B: begin
                    n_bits = {r_bits[tbsfd_pkg::TOTAL_BITS-3:0],
                              i_rx_byte[5], i_rx_byte[2]};
                    n_slot = tbsfd_pkg::SLOT_C;
                end
                tbsfd_pkg::SLOT_C: begin
                    n_bits = {r_bits[tbsfd_pkg::TOTAL_BITS-4:0],
                              i_rx_byte[7], i_rx_byte[4], i_rx_byte[1]};
                    n_slot = tbsfd_pkg::SLOT_A;
                end
                default: begin
                    n_slot = tbsfd_pkg::SLOT_A;
                end
            endcase
        end
    end

    assign o_frame.done        = i_accept && i_last_byte;
    assign o_frame.short_frame = n_count < tbsfd_pkg::NEED_CNT;
    assign o_frame.bits        = n_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_slot  <= tbsfd_pkg::SLOT_A;
        end else if (o_frame.done) begin
            r_count <= '0;
            r_slot  <= tbsfd_pkg::SLOT_A;
        end else begin
            r_count <= n_count;
            r_slot  <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
    end

endmodule

@@ hdl/tbsfd_frame_check.sv @@
// Marker and id copy check on a completed frame, forming the result fields.
module tbsfd_frame_check (
    input  tbsfd_pkg::t_frame  i_frame,
    output tbsfd_pkg::t_result o_result
);

    logic [7:0] b0, b1, b2, b3, b4, b5, b6, b7;
    logic       match;

    assign b0 = tbsfd_pkg::get_byte(i_frame.bits, 0);
    assign b1 = tbsfd_pkg::get_byte(i_frame.bits, 1);
    assign b2 = tbsfd_pkg::get_byte(i_frame.bits, 2);
    assign b3 = tbsfd_pkg::get_byte(i_frame.bits, 3);
    assign b4 = tbsfd_pkg::get_byte(i_frame.bits, 4);
    assign b5 = tbsfd_pkg::get_byte(i_frame.bits, 5);
    assign b6 = tbsfd_pkg::get_byte(i_frame.bits, 6);
    assign b7 = tbsfd_pkg::get_byte(i_frame.bits, 7);

    assign match = (b3 == tbsfd_pkg::MARK_A) && (b4 == tbsfd_pkg::MARK_B) &&
                   (b5 == tbsfd_pkg::MARK_C) && (b0 == b6) && (b1 == b7);

    always_comb begin
        o_result.status       = tbsfd_pkg::ST_VALID;
        o_result.unit_id      = '0;
        o_result.command_code = '0;
        if (i_frame.short_frame) begin
            o_result.status = tbsfd_pkg::ST_SHORT;
        end else if (!match) begin
            o_result.status = tbsfd_pkg::ST_MISMATCH;
        end else begin
            o_result.unit_id      = {b1, b0};
            o_result.command_code = b2;
        end
    end

endmodule

@@ hdl/tbsfd_out_buffer.sv @@
// Result register with skid stage on the output stream.
module tbsfd_out_buffer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tbsfd_pkg::t_result  i_result,
    output logic                o_space,
    output logic                o_valid,
    input  logic                i_ready,
    output tbsfd_pkg::t_result  o_result
);

    logic               r_out_valid, r_skid_valid;
    tbsfd_pkg::t_result r_out, r_skid;
    logic               out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_space  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end
        if (!out_free && i_push) begin
            r_skid <= i_result;
        end
    end

endmodule

@@ hdl/three_bit_symbol_frame_decoder_top.sv @@
// Three-bit symbol frame decoder: top level.
// A frame's result is registered at its last byte's transfer (skid stage if one waits).
// Throughput: 1 byte per cycle while the skid stage is empty; the result register
// and skid stage hold results so input transfers continue while one result waits.
// Reset (synchronous, active low) clears the byte count, symbol phase and
// output valid flags.
module three_bit_symbol_frame_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  logic        i_s_axis_tlast,   // last_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [15:0] unit_id, [23:16] command_code
    output logic [1:0]  o_m_axis_tuser    // [1:0] frame_status
);

    tbsfd_pkg::t_frame  frame;
    tbsfd_pkg::t_result result, out_result;
    logic               space;
    logic               accept;

    assign o_s_axis_tready = space;
    assign accept          = i_s_axis_tvalid && space;

    tbsfd_symbol_decoder u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_s_axis_tdata),
        .i_last_byte (i_s_axis_tlast),
        .o_frame     (frame)
    );

    tbsfd_frame_check u_check (
        .i_frame  (frame),
        .o_result (result)
    );

    tbsfd_out_buffer u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (frame.done),
        .i_result (result),
        .o_space  (space),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (out_result)
    );

    assign o_m_axis_tdata = {out_result.command_code, out_result.unit_id};
    assign o_m_axis_tuser = out_result.status;

endmodule
